// ===== src/ndvt_pkg.sv =====
// ----------------------------------------------------------------------------
// ndvt_pkg
// Shared types for the neighbor distance-vector table: operation codes and
// the control word broadcast from the sequencer to the neighbor cells.
// ----------------------------------------------------------------------------
package ndvt_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE  = 2'd0,
    OP_REFRESH = 2'd1,
    OP_ADD     = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_MATCH,
    CK_ROT,
    CK_STAMP,
    CK_LOAD,
    CK_SHIFT
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e  kind;
    logic        wr;     // replace the head entry while rotating
    logic        inc;    // head write is an append
    logic [31:0] nip;
    logic [31:0] dip;
    logic [31:0] stamp;
    logic [15:0] cost;
    logic [15:0] port;
    logic [15:0] lcost;
  } cell_ctl_t;

endpackage

// ===== src/neighbor_distance_vector_table.sv =====
// ----------------------------------------------------------------------------
// neighbor_distance_vector_table
// Ordered table of neighbor routers, each with its own destination-distance
// list. Route update, refresh, add and remove by index, one item at a time.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  command  | in        | start_i high, busy_o low  | operation_i .. remove_index_i
//  result   | out       | done_o, one cycle         | changed_o .. neighbor_count_o
//
//  Add and remove go through LOAD or SHIFT; an item that is dropped or ignored
//  is answered straight from idle. Refresh runs MATCH, a scan of the cell hit
//  flags (one slot a cycle) up to the neighbor hit, then STAMP; update runs
//  MATCH, the scan, then one full rotation of that cell's destination list.
//  A miss scans every slot below the neighbor count. busy_o is high meanwhile.
//  Reset clears the neighbor count and the sequencer; slot contents are
//  only read below the count and need no reset. Results cannot be stalled:
//  done_o marks the one cycle in which they are valid.
//
module neighbor_distance_vector_table #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int MAX_DESTS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic        is_route_control_i,
  input  logic [31:0] neighbor_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] route_cost_i,
  input  logic [15:0] neighbor_port_i,
  input  logic [15:0] neighbor_link_cost_i,
  input  logic [31:0] now_time_i,
  input  logic [4:0]  remove_index_i,
  output logic        done_o,
  output logic        changed_o,
  output logic        neighbor_found_o,
  output logic        table_full_o,
  output logic [4:0]  neighbor_count_o
);
  import ndvt_pkg::*;

  localparam int NW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int DCW = $clog2(MAX_DESTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_ROT,
    ST_STAMP,
    ST_LOAD,
    ST_SHIFT
  } state_e;

  state_e         state_q;
  op_e            op_q;
  logic [31:0]    nip_q, dip_q, time_q;
  logic [15:0]    rcost_q, nport_q, ncost_q;
  logic [4:0]     ridx_q;
  logic [CW-1:0]  count_q;
  logic [NW-1:0]  pos_q;     // scan index, then position of the hit
  logic [DCW-1:0] j_q;       // rotation step
  logic [DCW-1:0] n_q;       // destination count of the hit neighbor
  logic           dhit_q;    // destination already found in this rotation
  logic           changed_q, found_q, full_q, done_q;

  // per-slot wiring of the cell row
  logic [31:0]    c_addr  [MAX_NEIGHBORS];
  logic [15:0]    c_port  [MAX_NEIGHBORS];
  logic [15:0]    c_cost  [MAX_NEIGHBORS];
  logic [31:0]    c_stamp [MAX_NEIGHBORS];
  logic [DCW-1:0] c_dcnt  [MAX_NEIGHBORS];
  logic [31:0]    c_daddr [MAX_NEIGHBORS][MAX_DESTS];
  logic [15:0]    c_ddist [MAX_NEIGHBORS][MAX_DESTS];
  logic [MAX_NEIGHBORS-1:0] hit_vec;

  cell_ctl_t      ctl;
  logic [NW-1:0]  tgt;
  logic [31:0]    head_addr;
  logic [15:0]    head_dist;
  logic           rot_match, rot_append;
  logic [31:0]    cnt_ext;

  assign head_addr = c_daddr[pos_q][0];
  assign head_dist = c_ddist[pos_q][0];

  // live entries come first in the rotation, so a miss is known by step n
  assign rot_match  = (j_q < n_q) && !dhit_q && (head_addr == dip_q);
  assign rot_append = (j_q == n_q) && !dhit_q && (n_q < DCW'(MAX_DESTS));

  always_comb begin
    ctl.kind  = CK_NONE;
    ctl.wr    = 1'b0;
    ctl.inc   = 1'b0;
    ctl.nip   = nip_q;
    ctl.dip   = dip_q;
    ctl.stamp = time_q;
    ctl.cost  = rcost_q;
    ctl.port  = nport_q;
    ctl.lcost = ncost_q;
    tgt       = pos_q;
    unique case (state_q)
      ST_MATCH: ctl.kind = CK_MATCH;
      ST_ROT: begin
        ctl.kind = CK_ROT;
        ctl.wr   = rot_match || rot_append;
        ctl.inc  = rot_append;
      end
      ST_STAMP: ctl.kind = CK_STAMP;
      ST_LOAD: begin
        ctl.kind = CK_LOAD;
        tgt      = NW'(count_q);
      end
      ST_SHIFT: begin
        ctl.kind = CK_SHIFT;
        tgt      = NW'(ridx_q);
      end
      default: ctl.kind = CK_NONE;
    endcase
  end

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    localparam int Nx = (g == MAX_NEIGHBORS - 1) ? g : g + 1;
    ndvt_cell #(
      .MAX_DESTS(MAX_DESTS),
      .NW       (NW),
      .CW       (CW),
      .DCW      (DCW),
      .CellIdx  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .tgt_i      (tgt),
      .count_i    (count_q),
      .nxt_addr_i (c_addr[Nx]),
      .nxt_port_i (c_port[Nx]),
      .nxt_cost_i (c_cost[Nx]),
      .nxt_stamp_i(c_stamp[Nx]),
      .nxt_dcnt_i (c_dcnt[Nx]),
      .nxt_daddr_i(c_daddr[Nx]),
      .nxt_ddist_i(c_ddist[Nx]),
      .addr_o     (c_addr[g]),
      .port_o     (c_port[g]),
      .cost_o     (c_cost[g]),
      .stamp_o    (c_stamp[g]),
      .dcnt_o     (c_dcnt[g]),
      .daddr_o    (c_daddr[g]),
      .ddist_o    (c_ddist[g]),
      .hit_o      (hit_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      done_q    <= 1'b0;
      changed_q <= 1'b0;
      found_q   <= 1'b0;
      full_q    <= 1'b0;
      op_q      <= OP_UPDATE;
      pos_q     <= '0;
      j_q       <= '0;
      n_q       <= '0;
      dhit_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            op_q      <= op_e'(operation_i);
            nip_q     <= neighbor_ip_i;
            dip_q     <= dest_ip_i;
            rcost_q   <= route_cost_i;
            nport_q   <= neighbor_port_i;
            ncost_q   <= neighbor_link_cost_i;
            time_q    <= now_time_i;
            ridx_q    <= remove_index_i;
            changed_q <= 1'b0;
            found_q   <= 1'b0;
            full_q    <= 1'b0;
            unique case (op_e'(operation_i))
              OP_UPDATE: begin
                if (is_route_control_i) state_q <= ST_MATCH;
                else done_q <= 1'b1;
              end
              OP_REFRESH: state_q <= ST_MATCH;
              OP_ADD: begin
                if (count_q < CW'(MAX_NEIGHBORS)) begin
                  state_q <= ST_LOAD;
                end else begin
                  full_q <= 1'b1;
                  done_q <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (32'(remove_index_i) < 32'(count_q)) state_q <= ST_SHIFT;
                else done_q <= 1'b1;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_MATCH: begin
          pos_q <= '0;
          if (count_q == '0) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_vec[pos_q]) begin
            found_q <= 1'b1;
            n_q     <= c_dcnt[pos_q];
            j_q     <= '0;
            dhit_q  <= 1'b0;
            state_q <= (op_q == OP_UPDATE) ? ST_ROT : ST_STAMP;
          end else if ((CW'(pos_q) + CW'(1)) >= count_q) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            pos_q <= pos_q + NW'(1);
          end
        end
        ST_ROT: begin
          if (rot_match) begin
            dhit_q    <= 1'b1;
            changed_q <= (head_dist != rcost_q);
          end
          if (rot_append) begin
            changed_q <= 1'b1;
          end
          if (j_q == DCW'(MAX_DESTS - 1)) begin
            full_q  <= (n_q == DCW'(MAX_DESTS)) && !dhit_q && !rot_match;
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            j_q <= j_q + DCW'(1);
          end
        end
        ST_STAMP: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        ST_LOAD: begin
          count_q <= count_q + CW'(1);
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        ST_SHIFT: begin
          count_q <= count_q - CW'(1);
          found_q <= 1'b1;
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cnt_ext          = 32'(count_q);
  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign changed_o        = changed_q;
  assign neighbor_found_o = found_q;
  assign table_full_o     = full_q;
  assign neighbor_count_o = cnt_ext[4:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_NEIGHBORS))
    else $error("neighbor count above table size");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted item neither in work nor answered");

  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(changed_o && table_full_o))
    else $error("changed and table_full both set");

  a_count_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_o)
    else $error("neighbor count moved without a result");

endmodule

// ===== src/ndvt_cell.sv =====
// ----------------------------------------------------------------------------
// ndvt_cell
// One neighbor slot: address, port, link cost, stamp and a rotating list of
// destination entries. Takes the state of the next slot up on a compaction.
// ----------------------------------------------------------------------------
module ndvt_cell #(
  parameter int MAX_DESTS = 16,
  parameter int NW        = 4,
  parameter int CW        = 5,
  parameter int DCW       = 5,
  parameter int CellIdx   = 0
) (
  input  logic                 clk_i,
  input  ndvt_pkg::cell_ctl_t  ctl_i,
  input  logic [NW-1:0]        tgt_i,
  input  logic [CW-1:0]        count_i,
  input  logic [31:0]          nxt_addr_i,
  input  logic [15:0]          nxt_port_i,
  input  logic [15:0]          nxt_cost_i,
  input  logic [31:0]          nxt_stamp_i,
  input  logic [DCW-1:0]       nxt_dcnt_i,
  input  logic [31:0]          nxt_daddr_i [MAX_DESTS],
  input  logic [15:0]          nxt_ddist_i [MAX_DESTS],
  output logic [31:0]          addr_o,
  output logic [15:0]          port_o,
  output logic [15:0]          cost_o,
  output logic [31:0]          stamp_o,
  output logic [DCW-1:0]       dcnt_o,
  output logic [31:0]          daddr_o [MAX_DESTS],
  output logic [15:0]          ddist_o [MAX_DESTS],
  output logic                 hit_o
);
  import ndvt_pkg::*;

  logic [31:0]    addr_q;
  logic [15:0]    port_q;
  logic [15:0]    cost_q;
  logic [31:0]    stamp_q;
  logic [DCW-1:0] dcnt_q;
  logic [31:0]    daddr_q [MAX_DESTS];
  logic [15:0]    ddist_q [MAX_DESTS];
  logic           hit_q;
  logic           is_tgt;

  assign is_tgt = (tgt_i == NW'(CellIdx));

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.kind)
      CK_MATCH: begin
        hit_q <= (CW'(CellIdx) < count_i) && (addr_q == ctl_i.nip);
      end
      CK_ROT: begin
        if (is_tgt) begin
          // head leaves at slot 0 and re-enters at the tail
          for (int k = 0; k < MAX_DESTS - 1; k++) begin
            daddr_q[k] <= daddr_q[k+1];
            ddist_q[k] <= ddist_q[k+1];
          end
          daddr_q[MAX_DESTS-1] <= ctl_i.wr ? ctl_i.dip  : daddr_q[0];
          ddist_q[MAX_DESTS-1] <= ctl_i.wr ? ctl_i.cost : ddist_q[0];
          if (ctl_i.inc) begin
            dcnt_q <= dcnt_q + DCW'(1);
          end
        end
      end
      CK_STAMP: begin
        if (is_tgt) begin
          stamp_q <= ctl_i.stamp;
        end
      end
      CK_LOAD: begin
        if (is_tgt) begin
          addr_q     <= ctl_i.nip;
          port_q     <= ctl_i.port;
          cost_q     <= ctl_i.lcost;
          stamp_q    <= ctl_i.stamp;
          dcnt_q     <= DCW'(1);
          daddr_q[0] <= ctl_i.nip;
          ddist_q[0] <= 16'd0;
        end
      end
      CK_SHIFT: begin
        if (NW'(CellIdx) >= tgt_i) begin
          addr_q  <= nxt_addr_i;
          port_q  <= nxt_port_i;
          cost_q  <= nxt_cost_i;
          stamp_q <= nxt_stamp_i;
          dcnt_q  <= nxt_dcnt_i;
          daddr_q <= nxt_daddr_i;
          ddist_q <= nxt_ddist_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign addr_o  = addr_q;
  assign port_o  = port_q;
  assign cost_o  = cost_q;
  assign stamp_o = stamp_q;
  assign dcnt_o  = dcnt_q;
  assign daddr_o = daddr_q;
  assign ddist_o = ddist_q;
  assign hit_o   = hit_q;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Randomized check of the neighbor distance-vector table: a directed opening,
// then well-formed neighbor and route traffic, predicted in the bench and
// compared result by result.
// ----------------------------------------------------------------------------

// Scoreboard: own copy of the table, queue of predicted results.
class route_table_scoreboard;
  typedef struct packed {
    logic       changed;
    logic       found;
    logic       full;
    logic [4:0] count;
  } verdict_t;

  localparam int NMAX = 16;
  localparam int DMAX = 16;

  int unsigned nbr_count;
  logic [31:0] nbr_addr [NMAX];
  logic [31:0] nbr_stamp [NMAX];
  int unsigned dest_count [NMAX];
  logic [31:0] dest_addr [NMAX][DMAX];
  logic [15:0] dest_dist [NMAX][DMAX];
  verdict_t    pending [$];
  int unsigned mismatches;

  function new();
    nbr_count = 0;
    mismatches = 0;
  endfunction

  function int find_nbr(logic [31:0] addr);
    for (int i = 0; i < nbr_count; i++)
      if (nbr_addr[i] == addr) return i;
    return -1;
  endfunction

  // Apply one accepted command to the shadow table and queue its verdict.
  function void note_command(ndvt_pkg::op_e op, logic ctrl, logic [31:0] nip,
                             logic [31:0] dip, logic [15:0] rcost,
                             logic [31:0] now, logic [4:0] ridx);
    verdict_t v;
    int p;
    bit hit;
    v = '0;
    case (op)
      ndvt_pkg::OP_UPDATE: begin
        p = find_nbr(nip);
        if (ctrl && p >= 0) begin
          v.found = 1'b1;
          hit = 1'b0;
          for (int j = 0; j < dest_count[p]; j++)
            if (!hit && dest_addr[p][j] == dip) begin
              hit = 1'b1;
              v.changed = dest_dist[p][j] != rcost;
              dest_dist[p][j] = rcost;
            end
          if (!hit) begin
            if (dest_count[p] < DMAX) begin
              dest_addr[p][dest_count[p]] = dip;
              dest_dist[p][dest_count[p]] = rcost;
              dest_count[p]++;
              v.changed = 1'b1;
            end else begin
              v.full = 1'b1;
            end
          end
        end
      end
      ndvt_pkg::OP_REFRESH: begin
        p = find_nbr(nip);
        if (p >= 0) begin
          v.found = 1'b1;
          nbr_stamp[p] = now;
        end
      end
      ndvt_pkg::OP_ADD: begin
        if (nbr_count < NMAX) begin
          nbr_addr[nbr_count] = nip;
          nbr_stamp[nbr_count] = now;
          dest_addr[nbr_count][0] = nip;
          dest_dist[nbr_count][0] = '0;
          dest_count[nbr_count] = 1;
          nbr_count++;
        end else begin
          v.full = 1'b1;
        end
      end
      default: begin
        if (ridx < nbr_count) begin
          v.found = 1'b1;
          for (int i = ridx; i + 1 < nbr_count; i++) begin
            nbr_addr[i] = nbr_addr[i+1];
            nbr_stamp[i] = nbr_stamp[i+1];
            dest_count[i] = dest_count[i+1];
            dest_addr[i] = dest_addr[i+1];
            dest_dist[i] = dest_dist[i+1];
          end
          nbr_count--;
        end
      end
    endcase
    v.count = nbr_count[4:0];
    pending = {pending, v};
  endfunction

  function void check_result(verdict_t got);
    verdict_t exp_v;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_v = pending.pop_front();
    if (got !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected %p, got %p", exp_v, got);
    end
  endfunction
endclass

module tb_top;
  import ndvt_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  operation_i;
  logic        is_route_control_i;
  logic [31:0] neighbor_ip_i;
  logic [31:0] dest_ip_i;
  logic [15:0] route_cost_i;
  logic [15:0] neighbor_port_i;
  logic [15:0] neighbor_link_cost_i;
  logic [31:0] now_time_i;
  logic [4:0]  remove_index_i;
  logic        done_o;
  logic        changed_o;
  logic        neighbor_found_o;
  logic        table_full_o;
  logic [4:0]  neighbor_count_o;

  route_table_scoreboard board;
  int unsigned idle_pct;     // sender idle chance, per hundred, for this phase
  int unsigned quiet_cycles; // cycles since the last accepted item or result
  logic [31:0] addr_pool [8]; // small address pool so lookups hit often

  neighbor_distance_vector_table dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: results cannot be held off, so just sample every done_o.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      board.check_result({changed_o, neighbor_found_o, table_full_o, neighbor_count_o});
  end

  // Watchdog on cycles with no progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one item and hold it until accepted; random idle before it.
  task automatic send_item(op_e op, logic ctrl, logic [31:0] nip, logic [31:0] dip,
                           logic [15:0] rcost, logic [15:0] nport,
                           logic [15:0] ncost, logic [31:0] now, logic [4:0] ridx);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i              <= 1'b1;
    operation_i          <= op;
    is_route_control_i   <= ctrl;
    neighbor_ip_i        <= nip;
    dest_ip_i            <= dip;
    route_cost_i         <= rcost;
    neighbor_port_i      <= nport;
    neighbor_link_cost_i <= ncost;
    now_time_i           <= now;
    remove_index_i       <= ridx;
    do @(posedge clk_i); while (busy_o);
    board.note_command(op, ctrl, nip, dip, rcost, now, ridx);
  endtask

  // Let the table drain before changing the traffic pattern.
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(9) == 0) ? $urandom() : addr_pool[3'($urandom_range(7))];
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_item(OP_UPDATE, $urandom_range(15) != 0, pick_addr(),
                $urandom_range(19), 16'($urandom_range(3)), 16'($urandom()),
                16'($urandom()), $urandom(), 5'($urandom()));
    else if (pick < 67)
      send_item(OP_REFRESH, 1'($urandom()), pick_addr(), $urandom(), 16'($urandom()),
                16'($urandom()), 16'($urandom()), $urandom(), 5'($urandom()));
    else if (pick < 87)
      send_item(OP_ADD, 1'($urandom()), pick_addr(), $urandom(), 16'($urandom()),
                16'($urandom()), 16'($urandom()), $urandom(), 5'($urandom()));
    else
      send_item(OP_REMOVE, 1'($urandom()), $urandom(), $urandom(), 16'($urandom()),
                16'($urandom()), 16'($urandom()), $urandom(),
                5'($urandom_range(17)));
  endtask

  initial begin
    board = new();
    idle_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = OP_UPDATE;
    is_route_control_i = 1'b0;
    neighbor_ip_i = '0;
    dest_ip_i = '0;
    route_cost_i = '0;
    neighbor_port_i = '0;
    neighbor_link_cost_i = '0;
    now_time_i = '0;
    remove_index_i = '0;
    for (int i = 0; i < 8; i++) addr_pool[3'(i)] = $urandom();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unknown neighbor, non-control update, extremes.
    send_item(OP_REMOVE, 1'b1, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_REFRESH, 1'b1, '1, '0, '0, '0, '0, '1, '0);
    send_item(OP_ADD, 1'b0, '1, '0, '0, '1, '1, '1, '0);
    send_item(OP_ADD, 1'b1, '0, '1, '1, '0, '0, '0, '1);
    send_item(OP_UPDATE, 1'b0, '1, 32'd5, 16'd7, '0, '0, '0, '0);  // not route control
    send_item(OP_UPDATE, 1'b1, 32'h1234_5678, 32'd5, 16'd7, '0, '0, '0, '0); // unknown
    send_item(OP_UPDATE, 1'b1, '1, '1, '0, '0, '0, '0, '0);  // self entry, same distance
    send_item(OP_UPDATE, 1'b1, '1, '1, '1, '0, '0, '0, '0);  // distance change
    send_item(OP_UPDATE, 1'b1, '1, 32'h0a00_0001, 16'h8000, '0, '0, '0, '0); // append
    send_item(OP_UPDATE, 1'b1, '1, 32'h0a00_0001, 16'h8000, '0, '0, '0, '0); // same again
    send_item(OP_REFRESH, 1'b0, '0, '0, '0, '0, '0, 32'h5555_aaaa, '0);
    // fill one destination list past its end
    for (int k = 0; k < 16; k++)
      send_item(OP_UPDATE, 1'b1, '0, 32'(100 + k), 16'(k), '0, '0, '0, '0);
    drain();
    // fill the neighbor table, then one add too many
    for (int k = 0; k < 15; k++)
      send_item(OP_ADD, 1'b0, addr_pool[3'(k)], '0, '0, 16'($urandom()),
                16'($urandom()), $urandom(), '0);
    send_item(OP_REMOVE, 1'b0, '0, '0, '0, '0, '0, '0, 5'd16);    // out of range
    send_item(OP_REMOVE, 1'b0, '0, '0, '0, '0, '0, '0, 5'd15);    // last slot
    send_item(OP_REMOVE, 1'b0, '0, '0, '0, '0, '0, '0, 5'd31);
    send_item(OP_REMOVE, 1'b0, '0, '0, '0, '0, '0, '0, 5'd0);     // first slot
    drain();

    // Random phases: no idling, mostly idle, lightly idle, no idling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 67 : (ph == 2) ? 15 : 0;
      for (int k = 0; k < 380; k++) random_item();
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
